// File: sv/box_average_downsampler_top_assert.svh
// assertion macros for the box average downsampler
`ifndef BOX_AVERAGE_DOWNSAMPLER_TOP_ASSERT_SVH
`define BOX_AVERAGE_DOWNSAMPLER_TOP_ASSERT_SVH

// checked only outside reset
`define BOXAVG_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define BOXAVG_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/boxavg_pkg.sv
// shared types and constants of the box average downsampler
package boxavg_pkg;

  localparam int SIZE_W     = 11;   // in_width / in_height registers
  localparam int OSZ_W      = 7;    // out_width / out_height registers
  localparam int FAC_W      = 5;    // factor registers
  localparam int CNT_W      = 10;   // input column / row counters
  localparam int IDX_W      = 7;    // block indices
  localparam int COORD_W    = 6;    // output coordinates
  localparam int DIVISOR_W  = 10;   // factor_x * factor_y
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam int MAX_IN_SIZE    = 1024;
  localparam int MAX_OUT_HEIGHT = 64;
  localparam int INDEX_SAT      = 127;

  localparam logic [SIZE_W-1:0] RST_IN_WIDTH   = 11'd296;
  localparam logic [SIZE_W-1:0] RST_IN_HEIGHT  = 11'd240;
  localparam logic [OSZ_W-1:0]  RST_OUT_WIDTH  = 7'd8;
  localparam logic [OSZ_W-1:0]  RST_OUT_HEIGHT = 7'd8;
  localparam logic [FAC_W-1:0]  RST_FACTOR_X   = 5'd16;
  localparam logic [FAC_W-1:0]  RST_FACTOR_Y   = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH   = 3'd0,
    REG_IN_HEIGHT  = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_FACTOR_X   = 3'd4,
    REG_FACTOR_Y   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_BUSY,
    DIV_DONE
  } div_state_t;

  // effective sizes after clamping
  typedef struct packed {
    logic [FAC_W-1:0] fx;
    logic [FAC_W-1:0] fy;
    logic [OSZ_W-1:0] ow;
    logic [OSZ_W-1:0] oh;
  } cfg_lim_t;

  // where the current pixel falls
  typedef struct packed {
    logic             in_grid;
    logic             first;
    logic             done;
    logic             last;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } scan_info_t;

  // coordinates that travel with a block result
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } out_tag_t;

endpackage

// File: sv/box_average_downsampler_top.sv
// top level of the box average downsampler
//
// Pixels enter on in_valid/in_ready/pixel_in in raster order; block means leave on
// out_valid/out_ready with pixel_avg, out_col, out_row and frame_last. Registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data (cfg_ready is always high);
// write them only between frames or while no pixel is in flight.
// Each pixel inside the output grid reads its column sum from the sum line, adds itself
// in the next cycle and writes it back; a read that collides with the write just ahead
// takes the forwarded sum. Pixels that do not close a block stream at one per clock
// while the add stage is not held. A pixel that closes a block hands its sum to a shared
// divider that produces one quotient bit per cycle. The divider holds its result until
// out_ready; while it holds or works, a further block-closing pixel waits in the add
// stage and in_ready drops.
// Reset is synchronous: registers return to 296, 240, 8, 8, 16, 16, counters and the
// sum line's valid bits clear at once, and any pending result is dropped.
`include "box_average_downsampler_top_assert.svh"

module box_average_downsampler_top #(
  parameter int MAX_OUT_WIDTH = 64,
  parameter int MAX_FACTOR    = 16,
  parameter int PIXEL_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [boxavg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [boxavg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [PIXEL_BITS-1:0]               pixel_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [PIXEL_BITS-1:0]               pixel_avg,
  output logic [boxavg_pkg::COORD_W-1:0]      out_col,
  output logic [boxavg_pkg::COORD_W-1:0]      out_row,
  output logic                                frame_last
);

  localparam int FACB    = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 0;
  localparam int SUM_W   = PIXEL_BITS + 2 * FACB;
  localparam int AW      = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
  localparam int COORD_W = boxavg_pkg::COORD_W;
  localparam int DVW     = boxavg_pkg::DIVISOR_W;

  boxavg_pkg::cfg_lim_t   lim;
  boxavg_pkg::scan_info_t info;
  boxavg_pkg::out_tag_t   tag_in, tag_out;

  logic            in_accept;
  logic            rd_en;
  logic [AW-1:0]   scan_addr;
  logic [SUM_W-1:0] rd_data;

  // add stage
  logic                  s1_valid;
  logic                  s1_first, s1_done, s1_last, s1_hz;
  logic [AW-1:0]         s1_addr;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [COORD_W-1:0]    s1_col, s1_row;
  logic [SUM_W-1:0]      fwd_sum;
  logic [SUM_W-1:0]      base, sum;
  logic                  s1_retire;

  logic                  div_ready, div_start;
  logic [DVW-1:0]        divisor;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign scan_addr = AW'(info.col);
  assign rd_en     = in_accept && info.in_grid;

  boxavg_scan #(
    .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
    .MAX_FACTOR   (MAX_FACTOR)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .step     (in_accept),
    .lim      (lim),
    .info     (info)
  );

  boxavg_colmem #(
    .DEPTH(MAX_OUT_WIDTH),
    .AW   (AW),
    .DW   (SUM_W)
  ) u_colmem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_addr(scan_addr),
    .rd_data(rd_data),
    .wr_en  (s1_retire),
    .wr_addr(s1_addr),
    .wr_data(sum)
  );

  // a block-closing pixel leaves only when the divider can take it
  assign s1_retire = s1_valid && (!s1_done || div_ready);
  assign div_start = s1_valid && s1_done && div_ready;
  assign in_ready  = !s1_valid || s1_retire;

  always_comb begin
    if (s1_first) begin
      base = '0;
    end else if (s1_hz) begin
      base = fwd_sum;
    end else begin
      base = rd_data;
    end
    sum = base + SUM_W'(s1_pix);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rd_en) begin
      s1_valid <= 1'b1;
    end else if (s1_retire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_addr  <= scan_addr;
      s1_pix   <= pixel_in;
      s1_first <= info.first;
      s1_done  <= info.done;
      s1_last  <= info.last;
      s1_col   <= info.col[COORD_W-1:0];
      s1_row   <= info.row[COORD_W-1:0];
      // the write landing on this edge is missed by the memory read
      s1_hz    <= s1_retire && (s1_addr == scan_addr);
    end
    if (s1_retire) begin
      fwd_sum <= sum;
    end
  end

  assign divisor     = DVW'(lim.fx) * DVW'(lim.fy);
  assign tag_in.col  = s1_col;
  assign tag_in.row  = s1_row;
  assign tag_in.last = s1_last;

  boxavg_div #(
    .SUM_W     (SUM_W),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (divisor),
    .tag_in   (tag_in),
    .ready    (div_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .quotient (pixel_avg),
    .tag_out  (tag_out)
  );

  assign out_col    = tag_out.col;
  assign out_row    = tag_out.row;
  assign frame_last = tag_out.last;

  `BOXAVG_CHECK(a_frame_last_pos, (out_valid && frame_last) |-> ((out_col == COORD_W'(lim.ow - 7'd1)) && (out_row == COORD_W'(lim.oh - 7'd1))), "frame_last away from the last grid position")
  `BOXAVG_CHECK(a_s1_hold, (s1_valid && !s1_retire) |=> (s1_valid && $stable(s1_addr) && $stable(s1_pix)), "add stage lost a stalled pixel")
  `BOXAVG_CHECK(a_div_taken, div_start |=> !div_ready, "divider did not take a block sum")
  `BOXAVG_CHECK_ALWAYS(a_reset_clear, rst |=> (!s1_valid && !out_valid), "pipeline not cleared by reset")

endmodule

// File: sv/boxavg_scan.sv
// configuration registers and raster position counters
module boxavg_scan #(
  parameter int MAX_OUT_WIDTH = 64,
  parameter int MAX_FACTOR    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [boxavg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [boxavg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                step,
  output boxavg_pkg::cfg_lim_t                lim,
  output boxavg_pkg::scan_info_t              info
);

  localparam int SIZE_W = boxavg_pkg::SIZE_W;
  localparam int OSZ_W  = boxavg_pkg::OSZ_W;
  localparam int FAC_W  = boxavg_pkg::FAC_W;
  localparam int CNT_W  = boxavg_pkg::CNT_W;
  localparam int IDX_W  = boxavg_pkg::IDX_W;
  localparam int SUB_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

  logic [SIZE_W-1:0] in_width, in_height;
  logic [OSZ_W-1:0]  out_width, out_height;
  logic [FAC_W-1:0]  factor_x, factor_y;

  logic [CNT_W-1:0] in_col_count, in_row_count;
  logic [SUB_W-1:0] sub_col_count, sub_row_count;
  logic [IDX_W-1:0] block_col_index, block_row_index;

  logic [SIZE_W-1:0] w, h;
  logic              col_end, row_end, sub_col_end, sub_row_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= boxavg_pkg::RST_IN_WIDTH;
      in_height  <= boxavg_pkg::RST_IN_HEIGHT;
      out_width  <= boxavg_pkg::RST_OUT_WIDTH;
      out_height <= boxavg_pkg::RST_OUT_HEIGHT;
      factor_x   <= boxavg_pkg::RST_FACTOR_X;
      factor_y   <= boxavg_pkg::RST_FACTOR_Y;
    end else if (cfg_we) begin
      unique case (cfg_index)
        boxavg_pkg::REG_IN_WIDTH:   in_width   <= cfg_data;
        boxavg_pkg::REG_IN_HEIGHT:  in_height  <= cfg_data;
        boxavg_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data[OSZ_W-1:0];
        boxavg_pkg::REG_OUT_HEIGHT: out_height <= cfg_data[OSZ_W-1:0];
        boxavg_pkg::REG_FACTOR_X:   factor_x   <= cfg_data[FAC_W-1:0];
        boxavg_pkg::REG_FACTOR_Y:   factor_y   <= cfg_data[FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // zero input sizes and factors act as one; every oversize value clamps
  always_comb begin
    w = (in_width == '0) ? SIZE_W'(1) :
        (32'(in_width) > boxavg_pkg::MAX_IN_SIZE) ? SIZE_W'(boxavg_pkg::MAX_IN_SIZE) : in_width;
    h = (in_height == '0) ? SIZE_W'(1) :
        (32'(in_height) > boxavg_pkg::MAX_IN_SIZE) ? SIZE_W'(boxavg_pkg::MAX_IN_SIZE) : in_height;
    lim.fx = (factor_x == '0) ? FAC_W'(1) :
             (32'(factor_x) > MAX_FACTOR) ? FAC_W'(MAX_FACTOR) : factor_x;
    lim.fy = (factor_y == '0) ? FAC_W'(1) :
             (32'(factor_y) > MAX_FACTOR) ? FAC_W'(MAX_FACTOR) : factor_y;
    lim.ow = (32'(out_width) > MAX_OUT_WIDTH) ? OSZ_W'(MAX_OUT_WIDTH) : out_width;
    lim.oh = (32'(out_height) > boxavg_pkg::MAX_OUT_HEIGHT) ?
             OSZ_W'(boxavg_pkg::MAX_OUT_HEIGHT) : out_height;
  end

  always_comb begin
    col_end     = (32'(in_col_count) + 1) >= 32'(w);
    row_end     = (32'(in_row_count) + 1) >= 32'(h);
    sub_col_end = (32'(sub_col_count) + 1) >= 32'(lim.fx);
    sub_row_end = (32'(sub_row_count) + 1) >= 32'(lim.fy);

    info.col     = block_col_index;
    info.row     = block_row_index;
    info.in_grid = (block_col_index < IDX_W'(lim.ow)) && (block_row_index < IDX_W'(lim.oh));
    info.first   = (sub_col_count == '0) && (sub_row_count == '0);
    info.done    = ((32'(sub_col_count) + 1) == 32'(lim.fx)) &&
                   ((32'(sub_row_count) + 1) == 32'(lim.fy));
    info.last    = ((32'(block_col_index) + 1) == 32'(lim.ow)) &&
                   ((32'(block_row_index) + 1) == 32'(lim.oh));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col_count    <= '0;
      in_row_count    <= '0;
      sub_col_count   <= '0;
      sub_row_count   <= '0;
      block_col_index <= '0;
      block_row_index <= '0;
    end else if (step) begin
      if (col_end) begin
        in_col_count    <= '0;
        sub_col_count   <= '0;
        block_col_index <= '0;
        if (row_end) begin
          in_row_count    <= '0;
          sub_row_count   <= '0;
          block_row_index <= '0;
        end else begin
          in_row_count <= in_row_count + CNT_W'(1);
          if (sub_row_end) begin
            sub_row_count <= '0;
            if (32'(block_row_index) < boxavg_pkg::INDEX_SAT) begin
              block_row_index <= block_row_index + IDX_W'(1);
            end
          end else begin
            sub_row_count <= sub_row_count + SUB_W'(1);
          end
        end
      end else begin
        in_col_count <= in_col_count + CNT_W'(1);
        if (sub_col_end) begin
          sub_col_count <= '0;
          if (32'(block_col_index) < boxavg_pkg::INDEX_SAT) begin
            block_col_index <= block_col_index + IDX_W'(1);
          end
        end else begin
          sub_col_count <= sub_col_count + SUB_W'(1);
        end
      end
    end
  end

endmodule

// File: sv/boxavg_colmem.sv
// column sum line: registered-read memory with per-entry valid bits
module boxavg_colmem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [DW-1:0]    rdata;
  logic             rvld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld <= vld[rd_addr];
      end
    end
  end

  // an entry never written since reset reads as zero
  assign rd_data = rvld ? rdata : '0;

endmodule

// File: sv/boxavg_div.sv
// restoring divider, one quotient bit per cycle, result held for the output
module boxavg_div #(
  parameter int SUM_W      = 24,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [SUM_W-1:0]                     dividend,
  input  logic [boxavg_pkg::DIVISOR_W-1:0]     divisor,
  input  boxavg_pkg::out_tag_t                 tag_in,
  output logic                                 ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [PIXEL_BITS-1:0]                quotient,
  output boxavg_pkg::out_tag_t                 tag_out
);

  localparam int DVW   = boxavg_pkg::DIVISOR_W;
  localparam int STEPW = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  boxavg_pkg::div_state_t state, state_next;

  logic [SUM_W-1:0] q;
  logic [DVW-1:0]   rem;
  logic [DVW-1:0]   dvs;
  logic [STEPW-1:0] steps;
  logic [DVW:0]     trial;
  logic             ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= boxavg_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ready      = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      boxavg_pkg::DIV_IDLE: begin
        ready = 1'b1;
        if (start) begin
          state_next = boxavg_pkg::DIV_BUSY;
        end
      end
      boxavg_pkg::DIV_BUSY: begin
        if (steps == '0) begin
          state_next = boxavg_pkg::DIV_DONE;
        end
      end
      boxavg_pkg::DIV_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = boxavg_pkg::DIV_IDLE;
        end
      end
      default: state_next = boxavg_pkg::DIV_IDLE;
    endcase
  end

  // dividend bits shift out of q while quotient bits shift in
  assign trial = {rem, q[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (state == boxavg_pkg::DIV_IDLE && start) begin
      q       <= dividend;
      rem     <= '0;
      dvs     <= divisor;
      steps   <= STEPW'(SUM_W - 1);
      tag_out <= tag_in;
    end else if (state == boxavg_pkg::DIV_BUSY) begin
      rem   <= ge ? DVW'(trial - {1'b0, dvs}) : trial[DVW-1:0];
      q     <= {q[SUM_W-2:0], ge};
      steps <= steps - STEPW'(1);
    end
  end

  assign quotient = q[PIXEL_BITS-1:0];

endmodule
